/* rtl/core/mmpt_pkg.sv */
// shared types, field widths and codes for the bounded multimap pair table
// no dependencies
package mmpt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 6;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic    load;
        logic    add_wr;
        logic    adv;
        logic    shift_init;
        logic    shift_wr;
        logic    dec;
        logic    pend_load;
        logic    out_load;
        t_status out_status;
        logic    out_last;
        logic    out_use_pend;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic hit_k;
        logic hit_kv;
        logic scan_done;
        logic dv;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/mmpt_dpath.sv */
// datapath: pair store, pair count, scan pipeline and result register
// depends on mmpt_pkg
module mmpt_dpath #(
    parameter int CAPACITY = mmpt_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmpt_pkg::t_dp_cmd             i_cmd,
    output mmpt_pkg::t_dp_stat            o_stat,
    input  logic [mmpt_pkg::KEY_W-1:0]    i_key,
    input  logic [mmpt_pkg::VAL_W-1:0]    i_val,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output mmpt_pkg::t_status             o_status,
    output logic [mmpt_pkg::VAL_W-1:0]    o_value,
    output logic                          o_last,
    output logic [mmpt_pkg::CNT_OUT_W-1:0] o_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = mmpt_pkg::KEY_W + mmpt_pkg::VAL_W;

    logic [EW-1:0]                   mem [CAPACITY];
    logic [mmpt_pkg::KEY_W-1:0]      r_key;
    logic [mmpt_pkg::VAL_W-1:0]      r_val;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_ra;
    logic [IW-1:0]                   r_da;
    logic                            r_dv;
    logic [EW-1:0]                   r_rd;
    logic [mmpt_pkg::VAL_W-1:0]      r_pend_val;
    logic                            r_ovalid;
    mmpt_pkg::t_status               r_ostat;
    logic [mmpt_pkg::VAL_W-1:0]      r_oval;
    logic                            r_olast;
    logic [mmpt_pkg::CNT_OUT_W-1:0]  r_ocnt;
    logic                            w_ra_lt;
    logic [CW+mmpt_pkg::CNT_OUT_W-1:0] w_cnt_ext;
    logic [mmpt_pkg::KEY_W-1:0]      w_rd_key;
    logic [mmpt_pkg::VAL_W-1:0]      w_rd_val;

    assign w_ra_lt   = (r_ra < r_count);
    assign w_cnt_ext = {{mmpt_pkg::CNT_OUT_W{1'b0}}, r_count};
    assign w_rd_key  = r_rd[mmpt_pkg::KEY_W-1:0];
    assign w_rd_val  = r_rd[EW-1:mmpt_pkg::KEY_W];

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            mem[r_count[IW-1:0]] <= {r_val, r_key};
        end else if (i_cmd.shift_wr) begin
            mem[r_da - IW'(1)] <= r_rd;
        end
        if (i_cmd.adv && w_ra_lt) begin
            r_rd <= mem[r_ra[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ra     <= '0;
            r_da     <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.add_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load) begin
                r_ra <= '0;
                r_dv <= 1'b0;
            end else if (i_cmd.shift_init) begin
                r_ra <= CW'(r_da) + CW'(1);
                r_dv <= 1'b0;
            end else if (i_cmd.adv) begin
                r_dv <= w_ra_lt;
                r_da <= r_ra[IW-1:0];
                if (w_ra_lt) begin
                    r_ra <= r_ra + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_val <= i_val;
        end
        if (i_cmd.pend_load) begin
            r_pend_val <= w_rd_val;
        end
        if (i_cmd.out_load) begin
            r_ostat <= i_cmd.out_status;
            r_olast <= i_cmd.out_last;
            r_oval  <= i_cmd.out_use_pend ? r_pend_val : '0;
            r_ocnt  <= w_cnt_ext[mmpt_pkg::CNT_OUT_W-1:0];
        end
    end

    always_comb begin
        o_stat.full      = (r_count >= CW'(CAPACITY));
        o_stat.hit_k     = r_dv && (w_rd_key == r_key);
        o_stat.hit_kv    = r_dv && (w_rd_key == r_key) && (w_rd_val == r_val);
        o_stat.scan_done = !r_dv && !w_ra_lt;
        o_stat.dv        = r_dv;
        o_stat.out_free  = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_status   = r_ostat;
    assign o_value    = r_oval;
    assign o_last     = r_olast;
    assign o_count    = r_ocnt;

endmodule

/* rtl/core/mmpt_ctrl.sv */
// controller: sequences add, remove scan and shift, and search scan
// depends on mmpt_pkg
module mmpt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  mmpt_pkg::t_op      i_op,
    input  mmpt_pkg::t_dp_stat i_stat,
    output mmpt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RSCAN,
        S_RSHIFT,
        S_SRCH,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    mmpt_pkg::t_status r_fstat, n_fstat;
    logic              r_pend, n_pend;

    always_comb begin
        n_state    = r_state;
        n_fstat    = r_fstat;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_pend     = 1'b0;
                    unique case (i_op)
                        mmpt_pkg::OP_ADD: begin
                            if (i_stat.full) begin
                                n_fstat = mmpt_pkg::ST_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        mmpt_pkg::OP_REMOVE: n_state = S_RSCAN;
                        mmpt_pkg::OP_SEARCH: n_state = S_SRCH;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.add_wr = 1'b1;
                n_fstat      = mmpt_pkg::ST_OK;
                n_state      = S_FIN;
            end
            S_RSCAN: begin
                if (i_stat.hit_kv) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_RSHIFT;
                end else if (i_stat.scan_done) begin
                    n_fstat = mmpt_pkg::ST_NOT_FOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_RSHIFT: begin
                if (i_stat.scan_done) begin
                    o_cmd.dec = 1'b1;
                    n_fstat   = mmpt_pkg::ST_OK;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.adv      = 1'b1;
                    o_cmd.shift_wr = i_stat.dv;
                end
            end
            S_SRCH: begin
                if (i_stat.hit_k) begin
                    // earlier match goes out once a later one is known
                    if (!r_pend || i_stat.out_free) begin
                        o_cmd.adv          = 1'b1;
                        o_cmd.pend_load    = 1'b1;
                        o_cmd.out_load     = r_pend;
                        o_cmd.out_status   = mmpt_pkg::ST_OK;
                        o_cmd.out_use_pend = 1'b1;
                        n_pend             = 1'b1;
                    end
                end else if (i_stat.scan_done) begin
                    n_fstat = r_pend ? mmpt_pkg::ST_OK : mmpt_pkg::ST_NOT_FOUND;
                    n_state = S_FIN;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_status   = r_fstat;
                    o_cmd.out_last     = 1'b1;
                    o_cmd.out_use_pend = r_pend;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fstat <= mmpt_pkg::ST_OK;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fstat <= n_fstat;
            r_pend  <= n_pend;
        end
    end

endmodule

/* rtl/core/multimap_pair_table.sv */
// top level of the bounded multimap pair table: stream ports, controller and datapath
// depends on mmpt_pkg, mmpt_ctrl and mmpt_dpath
//
// channel   direction  tdata                        tuser          tlast
// s_axis    in         key[31:0], value[63:32]      cmd[1:0]       -
// m_axis    out        value[31:0], count[37:32]    status[1:0]    last of item
//
// remove and search scan the pair store through its single read port, one stored pair
// per cycle while not held; a remove that hits then shifts the later pairs down one place
// and reduces the pair count
// a stalled m_axis holds a search scan when a second result is due, and any item
// waits in its last cycle until the result register is free
// synchronous active-low reset empties the table; the store itself is not cleared
module multimap_pair_table #(
    parameter int CAPACITY = mmpt_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [mmpt_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // key, value
    input  logic [mmpt_pkg::OP_W-1:0]       i_s_axis_tuser,  // cmd
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mmpt_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,  // value_out, pair_count, zero pad
    output logic [mmpt_pkg::STATUS_W-1:0]   o_m_axis_tuser,  // status
    output logic                            o_m_axis_tlast
);

    localparam int KW = mmpt_pkg::KEY_W;
    localparam int VW = mmpt_pkg::VAL_W;
    localparam int NW = mmpt_pkg::CNT_OUT_W;

    mmpt_pkg::t_dp_cmd  w_cmd;
    mmpt_pkg::t_dp_stat w_st;
    mmpt_pkg::t_status  w_status;
    logic [VW-1:0]      w_value;
    logic [NW-1:0]      w_count;

    mmpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_op       (mmpt_pkg::t_op'(i_s_axis_tuser)),
        .i_stat     (w_st),
        .o_cmd      (w_cmd)
    );

    mmpt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_st),
        .i_key      (i_s_axis_tdata[KW-1:0]),
        .i_val      (i_s_axis_tdata[KW+VW-1:KW]),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_status   (w_status),
        .o_value    (w_value),
        .o_last     (o_m_axis_tlast),
        .o_count    (w_count)
    );

    assign o_m_axis_tuser = w_status;
    assign o_m_axis_tdata = {{(mmpt_pkg::M_TDATA_W - VW - NW){1'b0}}, w_count, w_value};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register loaded while a transfer is pending");

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.out_status == mmpt_pkg::ST_FULL) |-> w_st.full)
        else $error("full reported below capacity");

    a_not_found_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == mmpt_pkg::ST_NOT_FOUND)
            |-> (o_m_axis_tlast && o_m_axis_tdata[VW-1:0] == '0))
        else $error("not-found result is not a single zero-valued last transfer");
`endif

endmodule

/* tb/multimap_pair_table_tb.sv */
// testbench for multimap_pair_table: streams add, remove and search operations and unused command
// codes with random idling on both sides and checks every result against a pair table kept alongside
// depends on mmpt_pkg and multimap_pair_table
module multimap_pair_table_tb;

    localparam int CAPACITY = mmpt_pkg::CAPACITY_DEF;
    localparam int KW = mmpt_pkg::KEY_W;
    localparam int VW = mmpt_pkg::VAL_W;
    localparam int NW = mmpt_pkg::CNT_OUT_W;
    localparam int OW = mmpt_pkg::OP_W;
    localparam logic [OW-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_OPS = 330;
    localparam int QUIET_TAIL = 40;

    typedef struct {
        logic [OW-1:0] cmd;
        logic [KW-1:0] key;
        logic [VW-1:0] value;
    } t_op_item;

    typedef struct {
        mmpt_pkg::t_status status;
        logic [VW-1:0]     value;
        logic              last;
        logic [NW-1:0]     count;
    } t_result;

    logic                              i_clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_valid = 1'b0;
    logic [mmpt_pkg::S_TDATA_W-1:0]    s_tdata = '0;
    logic [OW-1:0]                     s_tuser = '0;
    logic                              m_ready = 1'b0;
    logic                              s_ready;
    logic                              m_valid;
    logic [mmpt_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [mmpt_pkg::STATUS_W-1:0]     m_tuser;
    logic                              m_tlast;

    t_op_item               op_queue[$];
    t_result                pending_results[$];
    t_op_item               cur_op;
    t_result                want;
    logic                   s_taken = 1'b0;
    string                  exp_txt;
    string                  got_txt;

    // shadow of the table used by the generator to pick removes that hit and to track its fill level
    logic [KW-1:0]          gen_keys[$];
    logic [VW-1:0]          gen_vals[$];

    logic [KW-1:0]          tbl_keys[CAPACITY];
    logic [VW-1:0]          tbl_vals[CAPACITY];
    int                     tbl_count = 0;

    int                     rst_cnt = 0;
    int                     src_gap = 0;
    int                     sink_stall = 0;
    int                     errs = 0;
    int                     n_ops = 0;
    int                     n_results = 0;
    int                     n_full = 0;
    int                     n_miss = 0;
    int                     deepest = 0;

    multimap_pair_table #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic queue_op(input logic [OW-1:0] c, input logic [KW-1:0] k,
                            input logic [VW-1:0] v);
        t_op_item it;
        int       j;
        int       pos;
        it.cmd   = c;
        it.key   = k;
        it.value = v;
        op_queue = {op_queue, it};
        pos = -1;
        if (c == mmpt_pkg::OP_ADD && gen_keys.size() < CAPACITY) begin
            gen_keys = {gen_keys, k};
            gen_vals = {gen_vals, v};
        end else if (c == mmpt_pkg::OP_REMOVE) begin
            for (j = 0; j < gen_keys.size(); j++)
                if (pos < 0 && gen_keys[j] == k && gen_vals[j] == v)
                    pos = j;
            if (pos >= 0) begin
                gen_keys.delete(pos);
                gen_vals.delete(pos);
            end
        end
    endtask

    task automatic queue_result(input mmpt_pkg::t_status st, input logic [VW-1:0] v,
                                input logic lst);
        t_result r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        r.count  = tbl_count[NW-1:0];
        pending_results = {pending_results, r};
    endtask

    task automatic apply_table_op(input t_op_item it);
        int i;
        int pos;
        int hits;
        int sent;
        pos  = -1;
        hits = 0;
        sent = 0;
        case (it.cmd)
            mmpt_pkg::OP_ADD: begin
                if (tbl_count >= CAPACITY) begin
                    n_full++;
                    queue_result(mmpt_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    tbl_keys[tbl_count] = it.key;
                    tbl_vals[tbl_count] = it.value;
                    tbl_count++;
                    queue_result(mmpt_pkg::ST_OK, '0, 1'b1);
                end
            end
            mmpt_pkg::OP_REMOVE: begin
                for (i = 0; i < tbl_count; i++)
                    if (pos < 0 && tbl_keys[i] == it.key && tbl_vals[i] == it.value)
                        pos = i;
                if (pos < 0) begin
                    n_miss++;
                    queue_result(mmpt_pkg::ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    for (i = pos; i + 1 < tbl_count; i++) begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_vals[i] = tbl_vals[i + 1];
                    end
                    tbl_count--;
                    queue_result(mmpt_pkg::ST_OK, '0, 1'b1);
                end
            end
            mmpt_pkg::OP_SEARCH: begin
                for (i = 0; i < tbl_count; i++)
                    if (tbl_keys[i] == it.key)
                        hits++;
                if (hits == 0) begin
                    n_miss++;
                    queue_result(mmpt_pkg::ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    for (i = 0; i < tbl_count; i++) begin
                        if (tbl_keys[i] == it.key) begin
                            sent++;
                            queue_result(mmpt_pkg::ST_OK, tbl_vals[i], sent == hits);
                        end
                    end
                    if (hits > deepest)
                        deepest = hits;
                end
            end
            default: ;
        endcase
    endtask

    // reset, driver and receiver, all driven on the falling edge
    always @(negedge i_clk) begin
        if (!rst_n) begin
            rst_cnt++;
            if (rst_cnt == 9)
                rst_n <= 1'b1;
        end else begin
            if (!(s_valid && !s_taken)) begin
                s_taken = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    cur_op = op_queue.pop_front();
                    s_tdata <= {cur_op.value, cur_op.key};
                    s_tuser <= cur_op.cmd;
                    s_valid <= 1'b1;
                    if (op_queue.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (op_queue.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
                    sink_stall = $urandom_range(1, 17);
            end
        end
    end

    // transfer sampling and result check on the rising edge
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_valid && s_ready) begin
                apply_table_op(cur_op);
                s_taken = 1'b1;
                n_ops++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                got_txt = $sformatf("status %0d value %h last %0b count %0d",
                                    m_tuser, m_tdata[VW-1:0], m_tlast, m_tdata[VW +: NW]);
                if (pending_results.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result, expected none, got %s", $time, got_txt);
                end else begin
                    want = pending_results.pop_front();
                    if (want.status !== m_tuser || want.value !== m_tdata[VW-1:0] ||
                        want.last !== m_tlast || want.count !== m_tdata[VW +: NW]) begin
                        errs++;
                        exp_txt = $sformatf("status %0d value %h last %0b count %0d",
                                            want.status, want.value, want.last, want.count);
                        $display("%0t: mismatch, expected %s, got %s", $time, exp_txt, got_txt);
                    end
                end
            end
        end
    end

    initial begin
        logic [KW-1:0] key_pool[8];
        logic [VW-1:0] val_pool[4];
        logic [KW-1:0] k;
        logic [VW-1:0] v;
        int            n_gen;
        int            r;
        int            j;
        int            full_adds;
        bit            filling;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7fff_ffff;
        for (j = 4; j < 8; j++)
            key_pool[j] = $urandom;
        val_pool[0] = 32'h0000_0000;
        val_pool[1] = 32'hffff_ffff;
        val_pool[2] = $urandom;
        val_pool[3] = $urandom_range(1, 9);

        // directed: empty table, extremes, duplicates, both kinds of failed remove
        queue_op(mmpt_pkg::OP_SEARCH, 32'h0000_0000, 32'hffff_ffff);
        queue_op(mmpt_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_ADD,    32'h0000_0000, 32'h7fff_ffff);
        queue_op(mmpt_pkg::OP_ADD,    32'hffff_ffff, 32'h8000_0000);
        queue_op(mmpt_pkg::OP_ADD,    32'h8000_0000, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_ADD,    32'h7fff_ffff, 32'hffff_ffff);
        queue_op(mmpt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0005);
        queue_op(mmpt_pkg::OP_ADD,    32'h0000_0000, 32'h7fff_ffff);
        queue_op(mmpt_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_SEARCH, 32'h1234_5678, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0006);
        queue_op(mmpt_pkg::OP_REMOVE, 32'h5555_5555, 32'h0000_0000);
        queue_op(OP_UNUSED,           32'hffff_ffff, 32'hffff_ffff);
        queue_op(mmpt_pkg::OP_REMOVE, 32'h0000_0000, 32'h7fff_ffff);
        queue_op(mmpt_pkg::OP_SEARCH, 32'h0000_0000, 32'hffff_ffff);
        queue_op(mmpt_pkg::OP_REMOVE, 32'h7fff_ffff, 32'hffff_ffff);
        queue_op(mmpt_pkg::OP_SEARCH, 32'hffff_ffff, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        queue_op(mmpt_pkg::OP_REMOVE, 32'hffff_ffff, 32'h8000_0000);
        queue_op(mmpt_pkg::OP_SEARCH, 32'hffff_ffff, 32'h0000_0000);

        // random: fill to full, try a few adds beyond, then drain to empty, repeatedly
        n_gen     = 0;
        full_adds = 0;
        filling   = 1'b1;
        while (n_gen < RANDOM_OPS) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 7)];
            v = ($urandom_range(0, 2) == 0) ? $urandom : val_pool[$urandom_range(0, 3)];
            if (r >= 96) begin
                queue_op(OP_UNUSED, $urandom, $urandom);
            end else begin
                n_gen++;
                if (r < (filling ? 62 : 15)) begin
                    if (gen_keys.size() == CAPACITY)
                        full_adds++;
                    queue_op(mmpt_pkg::OP_ADD, k, v);
                end else if (r < (filling ? 74 : 65) && gen_keys.size() != 0) begin
                    j = $urandom_range(0, gen_keys.size() - 1);
                    queue_op(mmpt_pkg::OP_REMOVE, gen_keys[j], gen_vals[j]);
                end else if (r < (filling ? 80 : 72)) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_op(mmpt_pkg::OP_REMOVE, k, $urandom);
                    else
                        queue_op(mmpt_pkg::OP_REMOVE, $urandom, v);
                end else begin
                    queue_op(mmpt_pkg::OP_SEARCH,
                             ($urandom_range(0, 4) == 0) ? $urandom : k, $urandom);
                end
                if (filling && full_adds >= 3) begin
                    filling   = 1'b0;
                    full_adds = 0;
                end else if (!filling && gen_keys.size() == 0) begin
                    filling = 1'b1;
                end
            end
        end

        @(posedge i_clk);
        while (op_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        $display("ran %0d operations and checked %0d results", n_ops, n_results);
        $display("store full %0d times, %0d not-found answers, longest search %0d values",
                 n_full, n_miss, deepest);
        if (errs == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mmpt_pkg.sv
rtl/core/mmpt_dpath.sv
rtl/core/mmpt_ctrl.sv
rtl/core/multimap_pair_table.sv
tb/multimap_pair_table_tb.sv
